@@ sv/embedding_table_sgd_engine_top_assert.svh @@
// Assertion macros for the checker file.
`ifndef EMBEDDING_TABLE_SGD_ENGINE_TOP_ASSERT_SVH
`define EMBEDDING_TABLE_SGD_ENGINE_TOP_ASSERT_SVH

// Generic form: explicit clock and active-low reset.
`define ETS_ASSERT_CR(label, ck, rn, prop, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Block clock and reset.
`define ETS_ASSERT(label, prop, msg) `ETS_ASSERT_CR(label, clk, arst_n, prop, msg)

`endif

@@ sv/ets_pkg.sv @@
`timescale 1ns / 1ps

package ets_pkg;

	localparam int VOCAB_ROWS_DEF = 1024;
	localparam int EMBED_DIM_DEF  = 64;

	localparam int REQ_W  = 2;
	localparam int TOK_W  = 10;
	localparam int DIM_W  = 6;
	localparam int VAL_W  = 16;
	localparam int GRAD_W = 24;
	localparam int LR_W   = 16;
	localparam int ALU_W  = 42;

	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 16;
	localparam int M_USER_W = 2;

	localparam logic [LR_W-1:0]   LR_RESET = 16'd655;
	localparam logic [GRAD_W-1:0] GRAD_MAX = 24'h7F_FFFF;
	localparam logic [GRAD_W-1:0] GRAD_MIN = 24'h80_0000;
	localparam logic [VAL_W-1:0]  W_MAX    = 16'h7FFF;
	localparam logic [VAL_W-1:0]  W_MIN    = 16'h8000;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_ACC    = 2'd1,
		REQ_APPLY  = 2'd2,
		REQ_WRITE  = 2'd3
	} req_e_t;

	typedef enum logic [1:0] {
		ALU_MUL = 2'd0,
		ALU_ADD = 2'd1,
		ALU_ACC = 2'd2,
		ALU_UPD = 2'd3
	} alu_op_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_AMUL,
		S_AADD,
		S_READ,
		S_EXEC,
		S_UPD,
		S_WB,
		S_OUT
	} state_t;

	typedef struct packed {
		logic                    en;
		alu_op_t                 op;
		logic signed [ALU_W-1:0] a;
		logic signed [ALU_W-1:0] b;
	} alu_cmd_t;

	typedef struct packed {
		logic rd_en;
		logic w_we;
		logic g_we;
	} st_cmd_t;

endpackage

@@ sv/ets_alu.sv @@
`timescale 1ns / 1ps

// Shared arithmetic unit: one multiplier, add, accumulate and update paths with saturation; result registered.
module ets_alu (
	input  logic                            clk,
	input  ets_pkg::alu_cmd_t               cmd,
	output logic signed [ets_pkg::ALU_W-1:0] res,
	output logic                            sat
);

	logic signed [42:0]              prod;
	logic signed [24:0]              acc;
	logic signed [25:0]              step;
	logic signed [26:0]              upd;
	logic signed [ets_pkg::ALU_W-1:0] res_d;
	logic                            sat_d;
	logic signed [ets_pkg::ALU_W-1:0] res_q;
	logic                            sat_q;

	always_comb begin
		prod  = $signed(cmd.a[17:0]) * $signed(cmd.b[24:0]);
		acc   = $signed({cmd.a[23], cmd.a[23:0]}) + $signed({{9{cmd.b[15]}}, cmd.b[15:0]});
		// floor of product / 2^16
		step  = $signed(cmd.b[41:16]);
		upd   = $signed({{11{cmd.a[15]}}, cmd.a[15:0]}) - $signed({step[25], step});
		res_d = '0;
		sat_d = 1'b0;
		unique case (cmd.op)
			ets_pkg::ALU_MUL: begin
				res_d = prod[ets_pkg::ALU_W-1:0];
			end
			ets_pkg::ALU_ADD: begin
				res_d = cmd.a + cmd.b;
			end
			ets_pkg::ALU_ACC: begin
				if (acc[24] != acc[23]) begin
					sat_d = 1'b1;
					res_d = acc[24] ? ets_pkg::ALU_W'($signed(ets_pkg::GRAD_MIN))
						: ets_pkg::ALU_W'($signed(ets_pkg::GRAD_MAX));
				end else begin
					res_d = ets_pkg::ALU_W'($signed(acc[23:0]));
				end
			end
			ets_pkg::ALU_UPD: begin
				if (upd[26:15] != {12{upd[15]}}) begin
					sat_d = 1'b1;
					res_d = upd[26] ? ets_pkg::ALU_W'($signed(ets_pkg::W_MIN))
						: ets_pkg::ALU_W'($signed(ets_pkg::W_MAX));
				end else begin
					res_d = ets_pkg::ALU_W'($signed(upd[15:0]));
				end
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			res_q <= res_d;
			sat_q <= sat_d;
		end
	end

	assign res = res_q;
	assign sat = sat_q;

endmodule

@@ sv/ets_store.sv @@
`timescale 1ns / 1ps

// Weight and gradient tables, one shared address, registered read data.
module ets_store #(
	parameter int DEPTH  = ets_pkg::VOCAB_ROWS_DEF * ets_pkg::EMBED_DIM_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                              clk,
	input  ets_pkg::st_cmd_t                  cmd,
	input  logic [ADDR_W-1:0]                 addr,
	input  logic [ets_pkg::VAL_W-1:0]         w_wdata,
	input  logic [ets_pkg::GRAD_W-1:0]        g_wdata,
	output logic signed [ets_pkg::VAL_W-1:0]  w_rd,
	output logic signed [ets_pkg::GRAD_W-1:0] g_rd
);

	logic [ets_pkg::VAL_W-1:0]  w_mem [DEPTH];
	logic [ets_pkg::GRAD_W-1:0] g_mem [DEPTH];
	logic [ets_pkg::VAL_W-1:0]  w_rd_q;
	logic [ets_pkg::GRAD_W-1:0] g_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.w_we) begin
			w_mem[addr] <= w_wdata;
		end
		if (cmd.rd_en) begin
			w_rd_q <= w_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.g_we) begin
			g_mem[addr] <= g_wdata;
		end
		if (cmd.rd_en) begin
			g_rd_q <= g_mem[addr];
		end
	end

	assign w_rd = $signed(w_rd_q);
	assign g_rd = $signed(g_rd_q);

endmodule

@@ sv/ets_ctrl.sv @@
`timescale 1ns / 1ps

// Request sequencer: clearing pass, address build, read, ALU steps, write-back.
module ets_ctrl #(
	parameter int VOCAB_ROWS = ets_pkg::VOCAB_ROWS_DEF,
	parameter int EMBED_DIM  = ets_pkg::EMBED_DIM_DEF,
	parameter int ADDR_W     = $clog2(VOCAB_ROWS * EMBED_DIM)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ets_pkg::REQ_W-1:0]         req_type,
	input  logic [ets_pkg::TOK_W-1:0]         token_index,
	input  logic [ets_pkg::DIM_W-1:0]         dim_index,
	input  logic [ets_pkg::VAL_W-1:0]         grad_value,
	input  logic [ets_pkg::VAL_W-1:0]         weight_value,
	input  logic [ets_pkg::LR_W-1:0]          learning_rate,
	input  logic                              out_free,
	output logic                              out_load,
	output logic [ets_pkg::VAL_W-1:0]         read_value,
	output logic                              saturated,
	output logic                              done_res,
	output ets_pkg::alu_cmd_t                 alu_cmd,
	input  logic signed [ets_pkg::ALU_W-1:0]  alu_res,
	input  logic                              alu_sat,
	output ets_pkg::st_cmd_t                  st_cmd,
	output logic [ADDR_W-1:0]                 st_addr,
	output logic [ets_pkg::VAL_W-1:0]         st_w_wdata,
	output logic [ets_pkg::GRAD_W-1:0]        st_g_wdata,
	input  logic signed [ets_pkg::VAL_W-1:0]  w_rd,
	input  logic signed [ets_pkg::GRAD_W-1:0] g_rd
);

	localparam int          TABLE_SIZE = VOCAB_ROWS * EMBED_DIM;
	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(TABLE_SIZE - 1);

	ets_pkg::state_t            state_q, state_d;
	ets_pkg::req_e_t            req_q;
	logic [ets_pkg::TOK_W-1:0]  tok_q;
	logic [ets_pkg::DIM_W-1:0]  dim_q;
	logic [ets_pkg::VAL_W-1:0]  grad_q;
	logic [ets_pkg::VAL_W-1:0]  wval_q;
	logic [ADDR_W-1:0]          addr_q;
	logic [ADDR_W-1:0]          sweep_q;
	logic [ADDR_W-1:0]          clr_q;
	logic [ets_pkg::VAL_W-1:0]  res_read_q;
	logic                       res_sat_q;
	logic                       res_done_q;
	logic [ADDR_W-1:0]          addr_now;
	logic                       in_range;
	logic                       accept;
	logic                       is_apply;

	assign in_range = (32'(token_index) < 32'(VOCAB_ROWS)) && (32'(dim_index) < 32'(EMBED_DIM));
	assign accept   = (state_q == ets_pkg::S_IDLE) && in_valid;
	assign is_apply = (req_q == ets_pkg::REQ_APPLY);
	assign addr_now = is_apply ? sweep_q : alu_res[ADDR_W-1:0];

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		out_load   = 1'b0;
		alu_cmd    = '0;
		st_cmd     = '0;
		st_addr    = addr_q;
		st_w_wdata = wval_q;
		st_g_wdata = '0;
		unique case (state_q)
			ets_pkg::S_CLEAR: begin
				st_cmd.g_we = 1'b1;
				st_addr     = clr_q;
				if (clr_q == LAST) begin
					state_d = ets_pkg::S_IDLE;
				end
			end
			ets_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (ets_pkg::req_e_t'(req_type) == ets_pkg::REQ_APPLY) begin
						state_d = ets_pkg::S_READ;
					end else if (in_range) begin
						state_d = ets_pkg::S_AMUL;
					end else begin
						state_d = ets_pkg::S_OUT;
					end
				end
			end
			ets_pkg::S_AMUL: begin
				alu_cmd.en = 1'b1;
				alu_cmd.op = ets_pkg::ALU_MUL;
				alu_cmd.a  = ets_pkg::ALU_W'(tok_q);
				alu_cmd.b  = ets_pkg::ALU_W'(EMBED_DIM);
				state_d    = ets_pkg::S_AADD;
			end
			ets_pkg::S_AADD: begin
				alu_cmd.en = 1'b1;
				alu_cmd.op = ets_pkg::ALU_ADD;
				alu_cmd.a  = alu_res;
				alu_cmd.b  = ets_pkg::ALU_W'(dim_q);
				state_d    = ets_pkg::S_READ;
			end
			ets_pkg::S_READ: begin
				st_cmd.rd_en = 1'b1;
				st_addr      = addr_now;
				state_d      = ets_pkg::S_EXEC;
			end
			ets_pkg::S_EXEC: begin
				unique case (req_q)
					ets_pkg::REQ_LOOKUP: begin
						state_d = ets_pkg::S_OUT;
					end
					ets_pkg::REQ_WRITE: begin
						st_cmd.w_we = 1'b1;
						state_d     = ets_pkg::S_OUT;
					end
					ets_pkg::REQ_ACC: begin
						alu_cmd.en = 1'b1;
						alu_cmd.op = ets_pkg::ALU_ACC;
						alu_cmd.a  = ets_pkg::ALU_W'(g_rd);
						alu_cmd.b  = ets_pkg::ALU_W'($signed(grad_q));
						state_d    = ets_pkg::S_WB;
					end
					ets_pkg::REQ_APPLY: begin
						alu_cmd.en = 1'b1;
						alu_cmd.op = ets_pkg::ALU_MUL;
						alu_cmd.a  = ets_pkg::ALU_W'(learning_rate);
						alu_cmd.b  = ets_pkg::ALU_W'(g_rd);
						state_d    = ets_pkg::S_UPD;
					end
					default: begin
						state_d = ets_pkg::S_OUT;
					end
				endcase
			end
			ets_pkg::S_UPD: begin
				alu_cmd.en = 1'b1;
				alu_cmd.op = ets_pkg::ALU_UPD;
				alu_cmd.a  = ets_pkg::ALU_W'(w_rd);
				alu_cmd.b  = alu_res;
				state_d    = ets_pkg::S_WB;
			end
			ets_pkg::S_WB: begin
				st_cmd.g_we = 1'b1;
				if (is_apply) begin
					// new weight, gradient cleared
					st_cmd.w_we = 1'b1;
					st_w_wdata  = alu_res[ets_pkg::VAL_W-1:0];
				end else begin
					st_g_wdata = alu_res[ets_pkg::GRAD_W-1:0];
				end
				state_d = ets_pkg::S_OUT;
			end
			ets_pkg::S_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ets_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ets_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ets_pkg::S_CLEAR;
			clr_q   <= '0;
			sweep_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ets_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ets_pkg::S_WB && is_apply) begin
				sweep_q <= (addr_q == LAST) ? '0 : addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q      <= ets_pkg::req_e_t'(req_type);
			tok_q      <= token_index;
			dim_q      <= dim_index;
			grad_q     <= grad_value;
			wval_q     <= weight_value;
			res_read_q <= '0;
			res_sat_q  <= 1'b0;
			res_done_q <= 1'b0;
		end
		if (state_q == ets_pkg::S_READ) begin
			addr_q <= addr_now;
		end
		if (state_q == ets_pkg::S_EXEC) begin
			if (req_q == ets_pkg::REQ_LOOKUP) begin
				res_read_q <= w_rd;
				res_done_q <= 1'b1;
			end
			if (req_q == ets_pkg::REQ_WRITE) begin
				res_done_q <= 1'b1;
			end
		end
		if (state_q == ets_pkg::S_WB) begin
			res_sat_q  <= alu_sat;
			res_done_q <= is_apply ? (addr_q == LAST) : 1'b1;
		end
	end

	assign read_value = res_read_q;
	assign saturated  = res_sat_q;
	assign done_res   = res_done_q;

endmodule

@@ sv/embedding_table_sgd_engine_top.sv @@
// From accept to m_tvalid: lookup and write go AMUL, AADD, READ, EXEC, OUT; accumulate adds WB
//   after EXEC; apply step goes READ, EXEC, UPD, WB, OUT; a non-apply index outside the table goes to OUT.
// One transaction at a time: the next is accepted only once the result is loaded, so an m_tready
//   stall holds the input too; one shared ALU and one memory port per table are used in turn.
// Reset (arst_n low, asynchronous): control cleared, learning_rate back to 655, then a
//   gradient clearing pass over VOCAB_ROWS*EMBED_DIM entries (65536 by default) with s_tready low.
`timescale 1ns / 1ps

module embedding_table_sgd_engine_top #(
	parameter int VOCAB_ROWS = ets_pkg::VOCAB_ROWS_DEF,
	parameter int EMBED_DIM  = ets_pkg::EMBED_DIM_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [9:0] token_index, [15:10] dim_index, [31:16] grad_value, [47:32] weight_value
	input  logic [ets_pkg::S_DATA_W-1:0]     s_tdata,
	// [1:0] req_type
	input  logic [ets_pkg::REQ_W-1:0]        s_tuser,
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [15:0] read_value
	output logic [ets_pkg::M_DATA_W-1:0]     m_tdata,
	// [0] saturated, [1] done_res
	output logic [ets_pkg::M_USER_W-1:0]     m_tuser,
	// learning_rate register
	input  logic                             cfg_wr_en,
	input  logic [ets_pkg::LR_W-1:0]         cfg_wr_data
);

	localparam int TABLE_SIZE = VOCAB_ROWS * EMBED_DIM;
	localparam int ADDR_W     = $clog2(TABLE_SIZE);

	logic [ets_pkg::LR_W-1:0]           lr_q;
	logic                               m_valid_q;
	logic [ets_pkg::M_DATA_W-1:0]       m_data_q;
	logic [ets_pkg::M_USER_W-1:0]       m_user_q;

	logic                               out_free;
	logic                               out_load;
	logic [ets_pkg::VAL_W-1:0]          read_value;
	logic                               saturated;
	logic                               done_res;

	ets_pkg::alu_cmd_t                  alu_cmd;
	logic signed [ets_pkg::ALU_W-1:0]   alu_res;
	logic                               alu_sat;

	ets_pkg::st_cmd_t                   st_cmd;
	logic [ADDR_W-1:0]                  st_addr;
	logic [ets_pkg::VAL_W-1:0]          st_w_wdata;
	logic [ets_pkg::GRAD_W-1:0]         st_g_wdata;
	logic signed [ets_pkg::VAL_W-1:0]   w_rd;
	logic signed [ets_pkg::GRAD_W-1:0]  g_rd;

	// output register frees as soon as the held transaction is taken
	assign out_free = !m_valid_q || m_tready;

	ets_ctrl #(
		.VOCAB_ROWS (VOCAB_ROWS),
		.EMBED_DIM  (EMBED_DIM),
		.ADDR_W     (ADDR_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.req_type      (s_tuser),
		.token_index   (s_tdata[9:0]),
		.dim_index     (s_tdata[15:10]),
		.grad_value    (s_tdata[31:16]),
		.weight_value  (s_tdata[47:32]),
		.learning_rate (lr_q),
		.out_free      (out_free),
		.out_load      (out_load),
		.read_value    (read_value),
		.saturated     (saturated),
		.done_res      (done_res),
		.alu_cmd       (alu_cmd),
		.alu_res       (alu_res),
		.alu_sat       (alu_sat),
		.st_cmd        (st_cmd),
		.st_addr       (st_addr),
		.st_w_wdata    (st_w_wdata),
		.st_g_wdata    (st_g_wdata),
		.w_rd          (w_rd),
		.g_rd          (g_rd)
	);

	// address build, accumulate and SGD step all share this unit
	ets_alu u_alu (
		.clk (clk),
		.cmd (alu_cmd),
		.res (alu_res),
		.sat (alu_sat)
	);

	ets_store #(
		.DEPTH  (TABLE_SIZE),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.cmd     (st_cmd),
		.addr    (st_addr),
		.w_wdata (st_w_wdata),
		.g_wdata (st_g_wdata),
		.w_rd    (w_rd),
		.g_rd    (g_rd)
	);

	// learning rate: plain write, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= ets_pkg::LR_RESET;
		end else if (cfg_wr_en) begin
			lr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= read_value;
			m_user_q <= {done_res, saturated};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

@@ sv/ets_checker.sv @@
`timescale 1ns / 1ps
`include "embedding_table_sgd_engine_top_assert.svh"

module ets_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [ets_pkg::S_DATA_W-1:0] s_tdata,
	input logic [ets_pkg::REQ_W-1:0]    s_tuser,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [ets_pkg::M_DATA_W-1:0] m_tdata,
	input logic [ets_pkg::M_USER_W-1:0] m_tuser
);

	// stalled result holds
	`ETS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// one request at a time: busy after every accepted transaction
	`ETS_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "accepted back to back")

	// a fresh result is only produced while the input side is closed
	`ETS_ASSERT(a_result_while_busy, $rose(m_tvalid) |-> !$past(s_tready), "result appeared without a request in flight")

	// nonzero read data only comes from a completed lookup
	`ETS_ASSERT(a_read_done, m_tvalid && (m_tdata != '0) |-> m_tuser[1], "read data without done")

	// an accepted request carries no unknown bits
	`ETS_ASSERT(a_tuser_known, s_tvalid && s_tready |-> !$isunknown(s_tuser) && !$isunknown(s_tdata), "unknown request accepted")

endmodule

bind embedding_table_sgd_engine_top ets_checker u_ets_checker (.*);
